FILE: hdl/mbss_pkg.sv
package mbss_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_OUT_W = 8;

  // Operation codes carried on the op field
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  // One pattern element as held in a cell
  typedef struct packed {
    logic [BYTE_W-1:0] pbyte;
    logic              wild;
    logic              first;
  } pat_elem_t;

  // Controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic              shift;
    logic              clear;
    logic              scan;
    logic              restart;
    logic [BYTE_W-1:0] data_byte;
  } cell_ctrl_t;

endpackage

FILE: hdl/mbss_if.sv
interface mbss_req_if;
  import mbss_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] data_byte;
  logic              wildcard_req;
  logic              restart;

  modport source (output valid, op, data_byte, wildcard_req, restart, input ready);
  modport sink   (input valid, op, data_byte, wildcard_req, restart, output ready);
endinterface

interface mbss_rsp_if;
  import mbss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 match_end;
  logic [1:0]           hit_count;
  logic                 unique_hit;
  logic                 pattern_error;
  logic [LEN_OUT_W-1:0] pattern_length;

  modport source (output valid, match_end, hit_count, unique_hit, pattern_error,
                  pattern_length, input ready);
  modport sink   (input valid, match_end, hit_count, unique_hit, pattern_error,
                  pattern_length, output ready);
endinterface

FILE: hdl/masked_byte_signature_scanner_unit.sv
// Wildcard byte-signature scanner. Load transactions (op 0) append one pattern
// element, exact byte or wildcard; restart on a load clears the pattern, hit
// count and error flags first. Scan transactions (op 1) stream data bytes;
// restart on a scan opens a new section so no match crosses it. Every
// transaction returns one registered result in the cycle after acceptance, and a new
// transaction is taken every cycle while the result register is free or being
// drained. The pattern lives in a row of MAX_PATTERN cells: a load that does not
// overflow shifts the row by one cell, so the last stored element always sits in
// cell 0, and a scan extends each cell's partial match from its higher neighbour,
// so the full-match flag is read from cell 0 alone. No clearing pass is needed after
// reset.
module masked_byte_signature_scanner_unit #(
  parameter int MAX_PATTERN = 128
) (
  input  logic       clk,
  input  logic       rst,
  mbss_req_if.sink   req,
  mbss_rsp_if.source rsp
);
  import mbss_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_next;
  logic [LEN_W-1:0] len_base;
  logic [1:0]       hits;
  logic [1:0]       hits_next;
  logic             any_exact;
  logic             any_exact_next;
  logic             overflowed;
  logic             overflowed_next;
  logic             first_wild;
  logic             first_wild_next;
  logic             err_now;
  logic             err_next;
  logic             match_now;
  logic             accept;
  logic             is_load;
  logic             full;

  cell_ctrl_t ctrl;
  pat_elem_t  pat_chain [MAX_PATTERN+1];
  logic       pm_chain  [MAX_PATTERN+1];
  logic       pm_next_chain [MAX_PATTERN];

  assign accept  = req.valid && req.ready;
  assign is_load = (req.op == OP_LOAD);
  assign req.ready = !rsp.valid || rsp.ready;

  // Length seen by this load, after an optional restart
  assign len_base = (req.restart) ? '0 : len;
  assign full     = (len_base == LEN_W'(MAX_PATTERN));

  // Drive the broadcast controls
  always_comb begin
    ctrl.shift     = accept && is_load && !full;
    ctrl.clear     = accept && is_load;
    ctrl.scan      = accept && (req.op == OP_SCAN);
    ctrl.restart   = req.restart;
    ctrl.data_byte = req.data_byte;
  end

  // New element enters cell 0; the far end gets no partial match
  assign pat_chain[0].pbyte = req.data_byte;
  assign pat_chain[0].wild  = req.wildcard_req;
  assign pat_chain[0].first = (len_base == '0);
  assign pm_chain[MAX_PATTERN] = 1'b0;

  for (genvar c = 0; c < MAX_PATTERN; c++) begin : g_cell
    mbss_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .pat_in      (pat_chain[c]),
      .pm_in       (pm_chain[c+1]),
      .pat_out     (pat_chain[c+1]),
      .pm_out      (pm_chain[c]),
      .pm_next_out (pm_next_chain[c])
    );
  end

  assign err_now   = (len == '0) || !any_exact || first_wild || overflowed;
  assign match_now = ctrl.scan && !err_now && pm_next_chain[0];

  // Work out the next pattern and hit state
  always_comb begin
    len_next        = len;
    hits_next       = hits;
    any_exact_next  = any_exact;
    overflowed_next = overflowed;
    first_wild_next = first_wild;
    if (accept && is_load) begin
      len_next = len_base;
      if (req.restart) begin
        hits_next       = 2'd0;
        any_exact_next  = 1'b0;
        overflowed_next = 1'b0;
      end
      if (full) begin
        overflowed_next = 1'b1;
      end else begin
        len_next = len_base + LEN_W'(1);
        if (!req.wildcard_req) begin
          any_exact_next = 1'b1;
        end
        if (len_base == '0) begin
          first_wild_next = req.wildcard_req;
        end
      end
    end else if (match_now && (hits != 2'd2)) begin
      hits_next = hits + 2'd1;
    end
  end

  assign err_next = (len_next == '0) || !any_exact_next || first_wild_next ||
                    overflowed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      len        <= '0;
      hits       <= 2'd0;
      any_exact  <= 1'b0;
      overflowed <= 1'b0;
      first_wild <= 1'b0;
    end else begin
      len        <= len_next;
      hits       <= hits_next;
      any_exact  <= any_exact_next;
      overflowed <= overflowed_next;
      first_wild <= first_wild_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.match_end      <= match_now;
      rsp.hit_count      <= hits_next;
      rsp.unique_hit     <= (hits_next == 2'd1);
      rsp.pattern_error  <= err_next;
      rsp.pattern_length <= LEN_OUT_W'(len_next);
    end
  end

endmodule

FILE: hdl/mbss_cell.sv
module mbss_cell (
  input  logic                clk,
  input  logic                rst,
  input  mbss_pkg::cell_ctrl_t ctrl,
  input  mbss_pkg::pat_elem_t  pat_in,
  input  logic                pm_in,
  output mbss_pkg::pat_elem_t  pat_out,
  output logic                pm_out,
  output logic                pm_next_out
);
  import mbss_pkg::*;

  pat_elem_t pat;
  logic      pm;
  logic      pm_next;
  logic      elem_hit;

  // Compare the broadcast byte against the held element
  assign elem_hit = pat.wild || (pat.pbyte == ctrl.data_byte);

  // Extend the partial match from the neighbour holding the previous element
  always_comb begin
    pm_next = pm;
    if (ctrl.clear) begin
      pm_next = 1'b0;
    end else if (ctrl.scan) begin
      pm_next = elem_hit && (pat.first || (!ctrl.restart && pm_in));
    end
  end

  // Shift the pattern along the row on a load
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      pat <= pat_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pm <= 1'b0;
    end else begin
      pm <= pm_next;
    end
  end

  assign pat_out     = pat;
  assign pm_out      = pm;
  assign pm_next_out = pm_next;

endmodule
